FILE: rtl/core/boids_flocking_force_top_macros.svh
// assertion helpers shared by the flocking force rtl
`ifndef BOIDS_FLOCKING_FORCE_TOP_MACROS_SVH
`define BOIDS_FLOCKING_FORCE_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define BFF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define BFF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/bff_pkg.sv
// ----------------------------------------------------------------------------
// bff_pkg
// shared types and constants of the flocking force unit
// ----------------------------------------------------------------------------
package bff_pkg;

  localparam int MAX_MEMBERS = 64;
  localparam int SLOT_W      = $clog2(MAX_MEMBERS);
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SEP_RADIUS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALI_RADIUS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COH_RADIUS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SEP_WEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ALI_WEIGHT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_COH_WEIGHT = 3'd5;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  typedef enum logic [1:0] {
    FUNC_STORE  = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_QUERY  = 2'd2,
    FUNC_RSVD   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    OP_STORE  = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2
  } op_e;

  typedef struct packed {
    logic [1:0]         func;
    logic [5:0]         slot;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [23:0] vel_x;
    logic signed [23:0] vel_y;
    logic signed [23:0] vel_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic               status;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [23:0] vel_x;
    logic signed [23:0] vel_y;
    logic signed [23:0] vel_z;
  } member_t;

  typedef struct packed {
    op_e               op;
    logic [SLOT_W-1:0] slot;
    member_t           mbr;
  } cmd_t;

  typedef struct packed {
    logic [30:0] sep_radius;
    logic [30:0] ali_radius;
    logic [30:0] coh_radius;
    logic [15:0] sep_weight;
    logic [15:0] ali_weight;
    logic [15:0] coh_weight;
  } cfg_t;

  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [24:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic        start;
    logic [63:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] root;
  } sqrt_rsp_t;

endpackage

FILE: rtl/core/bff_front.sv
// ----------------------------------------------------------------------------
// bff_front
// accepts items, decodes the function code and queues commands
// ----------------------------------------------------------------------------
module bff_front (
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  bff_pkg::in_item_t in_data_i,
  input  logic              q_full_i,
  output logic              push_o,
  output bff_pkg::cmd_t     cmd_o
);
  import bff_pkg::*;

  logic known;

  always_comb begin
    known  = 1'b1;
    cmd_o.op = OP_QUERY;
    unique case (func_e'(in_data_i.func))
      FUNC_STORE:  cmd_o.op = OP_STORE;
      FUNC_REMOVE: cmd_o.op = OP_REMOVE;
      FUNC_QUERY:  cmd_o.op = OP_QUERY;
      default:     known = 1'b0; // unused code, dropped
    endcase
    cmd_o.slot      = in_data_i.slot;
    cmd_o.mbr.pos_x = in_data_i.pos_x;
    cmd_o.mbr.pos_y = in_data_i.pos_y;
    cmd_o.mbr.pos_z = in_data_i.pos_z;
    cmd_o.mbr.vel_x = in_data_i.vel_x;
    cmd_o.mbr.vel_y = in_data_i.vel_y;
    cmd_o.mbr.vel_z = in_data_i.vel_z;
  end

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i && known;

endmodule

FILE: rtl/core/bff_queue.sv
// ----------------------------------------------------------------------------
// bff_queue
// two-entry command queue between front and back
// ----------------------------------------------------------------------------
module bff_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  bff_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output bff_pkg::cmd_t data_o,
  output logic          empty_o
);
  import bff_pkg::*;

  cmd_t       ent_q [2];
  logic       wr_q;
  logic       rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = ent_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

FILE: rtl/core/bff_div.sv
// ----------------------------------------------------------------------------
// bff_div
// restoring divider, one quotient bit per cycle, 25-bit quotient
// ----------------------------------------------------------------------------
module bff_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bff_pkg::div_req_t req_i,
  output bff_pkg::div_rsp_t rsp_o
);
  import bff_pkg::*;

  logic        busy_q;
  logic        done_q;
  logic [4:0]  cnt_q;
  logic [63:0] rem_q;
  logic [63:0] den_q;
  logic [24:0] num_q;
  logic [24:0] quot_q;
  logic [64:0] trial;
  logic [64:0] diff;
  logic        qbit;

  // caller guarantees num[63:25] < den
  always_comb begin
    trial = {rem_q, num_q[24]};
    diff  = trial - {1'b0, den_q};
    qbit  = (trial >= {1'b0, den_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      den_q  <= '0;
      num_q  <= '0;
      quot_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'd25;
        rem_q  <= {25'b0, req_i.num[63:25]};
        num_q  <= req_i.num[24:0];
        den_q  <= req_i.den;
        quot_q <= '0;
      end else if (busy_q) begin
        rem_q  <= qbit ? diff[63:0] : trial[63:0];
        num_q  <= {num_q[23:0], 1'b0};
        quot_q <= {quot_q[23:0], qbit};
        cnt_q  <= cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

FILE: rtl/core/bff_sqrt.sv
// ----------------------------------------------------------------------------
// bff_sqrt
// bitwise integer square root of a 64-bit value, one bit per cycle
// ----------------------------------------------------------------------------
module bff_sqrt (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bff_pkg::sqrt_req_t req_i,
  output bff_pkg::sqrt_rsp_t rsp_o
);
  import bff_pkg::*;

  logic        busy_q;
  logic        done_q;
  logic [5:0]  cnt_q;
  logic [63:0] n_q;
  logic [63:0] r_q;
  logic [63:0] b_q;
  logic [63:0] rb;

  assign rb = r_q + b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      n_q    <= '0;
      r_q    <= '0;
      b_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd32;
        n_q    <= req_i.radicand;
        r_q    <= '0;
        b_q    <= 64'h4000_0000_0000_0000;
      end else if (busy_q) begin
        if (n_q >= rb) begin
          n_q <= n_q - rb;
          r_q <= (r_q >> 1) + b_q;
        end else begin
          r_q <= r_q >> 1;
        end
        b_q   <= b_q >> 2;
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.root = r_q[31:0];

endmodule

FILE: rtl/core/bff_back.sv
// ----------------------------------------------------------------------------
// bff_back
// member table and force sequencer: store, remove and query execution
// ----------------------------------------------------------------------------
`include "boids_flocking_force_top_macros.svh"

module bff_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bff_pkg::cfg_t      cfg_i,
  input  logic               q_empty_i,
  input  bff_pkg::cmd_t      q_data_i,
  output logic               q_pop_o,
  output bff_pkg::div_req_t  div_req_o,
  input  bff_pkg::div_rsp_t  div_rsp_i,
  output bff_pkg::sqrt_req_t sqrt_req_o,
  input  bff_pkg::sqrt_rsp_t sqrt_rsp_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output bff_pkg::out_item_t res_o
);
  import bff_pkg::*;

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_MY       = 5'd1;
  localparam logic [4:0] S_RAD      = 5'd2;
  localparam logic [4:0] S_RD       = 5'd3;
  localparam logic [4:0] S_OFF      = 5'd4;
  localparam logic [4:0] S_SQ       = 5'd5;
  localparam logic [4:0] S_CLS      = 5'd6;
  localparam logic [4:0] S_SDIV     = 5'd7;
  localparam logic [4:0] S_SWAIT    = 5'd8;
  localparam logic [4:0] S_UV_LD    = 5'd9;
  localparam logic [4:0] S_UV_NORM  = 5'd10;
  localparam logic [4:0] S_UV_SQ    = 5'd11;
  localparam logic [4:0] S_UV_ROOT  = 5'd12;
  localparam logic [4:0] S_UV_RWAIT = 5'd13;
  localparam logic [4:0] S_UV_DIV   = 5'd14;
  localparam logic [4:0] S_UV_DWAIT = 5'd15;
  localparam logic [4:0] S_FIN      = 5'd16;
  localparam logic [4:0] S_OUT      = 5'd17;

  localparam logic signed [47:0] SEP_LIMIT = 48'sh4000_0000_0000;
  localparam logic signed [65:0] F_MAX     = 66'sh7FFF_FFFF;
  localparam logic signed [65:0] F_MIN     = ~F_MAX;

  // member table
  member_t           mem [MAX_MEMBERS];
  member_t           rd_q;
  logic [SLOT_W-1:0] rd_addr;
  logic              mem_we;
  logic [MAX_MEMBERS-1:0] valid_q;

  logic [4:0]        state_q;
  logic [SLOT_W-1:0] slot_q;
  logic [SLOT_W-1:0] j_q;
  logic [1:0]        cnt_q;
  logic [2:0]        step_q;
  logic              pass_q;
  logic              status_q;

  logic signed [31:0] my_q   [3];
  logic [61:0]        rsq_q  [3];
  logic signed [32:0] o_q    [3];
  logic [63:0]        d2_q;
  logic signed [47:0] sep_q  [3];
  logic signed [38:0] vsum_q [3];
  logic signed [38:0] cdir_q [3];
  logic [37:0]        uvm_q  [3];
  logic [2:0]         uvneg_q;
  logic [49:0]        s_q;
  logic [31:0]        len_q;
  logic signed [17:0] ali_q  [3];
  logic signed [17:0] coh_q  [3];
  logic signed [65:0] acc_q;
  logic signed [31:0] frc_q  [3];

  // combinational helpers
  logic signed [31:0] rpos   [3];
  logic signed [23:0] rvel   [3];
  logic signed [32:0] diff   [3];
  logic [32:0]        dmag   [3];
  logic               far;
  logic [30:0]        omag;
  logic               oneg;
  logic [30:0]        rad_sel;
  logic               last_j;
  logic               sep_hit;
  logic               ali_hit;
  logic               coh_hit;
  logic signed [47:0] q48;
  logic signed [47:0] sep_n;
  logic signed [38:0] uv_src [3];
  logic               uv_zero;
  logic               uv_big;
  logic signed [17:0] uq;
  logic [39:0]        mul_lo;
  logic signed [40:0] mul_hi;
  logic signed [33:0] mul_ali;
  logic signed [33:0] mul_coh;
  logic signed [65:0] adj;
  logic signed [65:0] shr;
  logic signed [31:0] sat;

  always_comb begin
    rpos[0] = rd_q.pos_x;
    rpos[1] = rd_q.pos_y;
    rpos[2] = rd_q.pos_z;
    rvel[0] = rd_q.vel_x;
    rvel[1] = rd_q.vel_y;
    rvel[2] = rd_q.vel_z;
    far = 1'b0;
    for (int i = 0; i < 3; i++) begin
      diff[i] = 33'(rpos[i]) - 33'(my_q[i]);
      dmag[i] = diff[i][32] ? 33'(-diff[i]) : 33'(diff[i]);
      if (dmag[i][32:31] != 2'b00) begin
        far = 1'b1;
      end
      uv_src[i] = pass_q ? cdir_q[i] : vsum_q[i];
    end
    oneg = o_q[cnt_q][32];
    omag = oneg ? 31'(-o_q[cnt_q]) : 31'(o_q[cnt_q]);
    case (cnt_q)
      2'd0:    rad_sel = cfg_i.sep_radius;
      2'd1:    rad_sel = cfg_i.ali_radius;
      default: rad_sel = cfg_i.coh_radius;
    endcase
    last_j  = (j_q == SLOT_W'(MAX_MEMBERS - 1));
    sep_hit = (d2_q != 64'd0) && (d2_q < {2'b00, rsq_q[0]});
    ali_hit = (d2_q < {2'b00, rsq_q[1]});
    coh_hit = (d2_q < {2'b00, rsq_q[2]});
    q48     = $signed({23'b0, div_rsp_i.quot});
    sep_n   = sep_q[cnt_q] + (oneg ? q48 : -q48);
    uv_zero = (uvm_q[0] == '0) && (uvm_q[1] == '0) && (uvm_q[2] == '0);
    uv_big  = (uvm_q[0][37:24] != '0) || (uvm_q[1][37:24] != '0) ||
              (uvm_q[2][37:24] != '0);
    uq      = $signed({1'b0, div_rsp_i.quot[16:0]});
    mul_lo  = sep_q[cnt_q][23:0] * cfg_i.sep_weight;
    mul_hi  = $signed(sep_q[cnt_q][47:24]) * $signed({1'b0, cfg_i.sep_weight});
    mul_ali = ali_q[cnt_q] * $signed({1'b0, cfg_i.ali_weight});
    mul_coh = coh_q[cnt_q] * $signed({1'b0, cfg_i.coh_weight});
    // divide by 256 truncating toward zero, then saturate
    adj = acc_q + (acc_q[65] ? 66'sd255 : 66'sd0);
    shr = adj >>> 8;
    if (shr > F_MAX) begin
      sat = F_MAX[31:0];
    end else if (shr < F_MIN) begin
      sat = F_MIN[31:0];
    end else begin
      sat = shr[31:0];
    end
  end

  assign q_pop_o = (state_q == S_IDLE) && !q_empty_i;
  assign mem_we  = q_pop_o && (q_data_i.op == OP_STORE);
  assign rd_addr = (state_q == S_IDLE) ? q_data_i.slot : j_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[q_data_i.slot] <= q_data_i.mbr;
    end
    rd_q <= mem[rd_addr];
  end

  always_comb begin
    div_req_o.start = (state_q == S_SDIV) || (state_q == S_UV_DIV);
    if (state_q == S_SDIV) begin
      div_req_o.num = 64'(omag) << 24;
      div_req_o.den = d2_q;
    end else begin
      div_req_o.num = 64'(uvm_q[cnt_q][23:0]) << 23;
      div_req_o.den = {32'b0, len_q};
    end
    sqrt_req_o.start    = (state_q == S_UV_ROOT);
    sqrt_req_o.radicand = {s_q, 14'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      valid_q  <= '0;
      slot_q   <= '0;
      j_q      <= '0;
      cnt_q    <= '0;
      step_q   <= '0;
      pass_q   <= 1'b0;
      status_q <= STATUS_OK;
      my_q     <= '{default: '0};
      rsq_q    <= '{default: '0};
      o_q      <= '{default: '0};
      d2_q     <= '0;
      sep_q    <= '{default: '0};
      vsum_q   <= '{default: '0};
      cdir_q   <= '{default: '0};
      uvm_q    <= '{default: '0};
      uvneg_q  <= '0;
      s_q      <= '0;
      len_q    <= '0;
      ali_q    <= '{default: '0};
      coh_q    <= '{default: '0};
      acc_q    <= '0;
      frc_q    <= '{default: '0};
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (!q_empty_i) begin
            slot_q <= q_data_i.slot;
            case (q_data_i.op)
              OP_STORE:  valid_q[q_data_i.slot] <= 1'b1;
              OP_REMOVE: valid_q[q_data_i.slot] <= 1'b0;
              OP_QUERY: begin
                if (!valid_q[q_data_i.slot]) begin
                  frc_q    <= '{default: '0};
                  status_q <= STATUS_EMPTY;
                  state_q  <= S_OUT;
                end else begin
                  status_q <= STATUS_OK;
                  state_q  <= S_MY;
                end
              end
              default: ;
            endcase
          end
        end
        S_MY: begin
          my_q[0] <= rd_q.pos_x;
          my_q[1] <= rd_q.pos_y;
          my_q[2] <= rd_q.pos_z;
          cnt_q   <= 2'd0;
          state_q <= S_RAD;
        end
        S_RAD: begin
          rsq_q[cnt_q] <= rad_sel * rad_sel;
          if (cnt_q == 2'd2) begin
            j_q     <= '0;
            sep_q   <= '{default: '0};
            vsum_q  <= '{default: '0};
            cdir_q  <= '{default: '0};
            state_q <= S_RD;
          end else begin
            cnt_q <= cnt_q + 2'd1;
          end
        end
        S_RD: begin
          if (!valid_q[j_q] || (j_q == slot_q)) begin
            if (last_j) begin
              pass_q  <= 1'b0;
              state_q <= S_UV_LD;
            end else begin
              j_q <= j_q + SLOT_W'(1);
            end
          end else begin
            state_q <= S_OFF;
          end
        end
        S_OFF: begin
          o_q   <= diff;
          d2_q  <= '0;
          cnt_q <= 2'd0;
          if (far) begin
            if (last_j) begin
              pass_q  <= 1'b0;
              state_q <= S_UV_LD;
            end else begin
              j_q     <= j_q + SLOT_W'(1);
              state_q <= S_RD;
            end
          end else begin
            state_q <= S_SQ;
          end
        end
        S_SQ: begin
          d2_q <= d2_q + 64'(omag * omag);
          if (cnt_q == 2'd2) begin
            state_q <= S_CLS;
          end else begin
            cnt_q <= cnt_q + 2'd1;
          end
        end
        S_CLS: begin
          for (int i = 0; i < 3; i++) begin
            if (ali_hit) begin
              vsum_q[i] <= vsum_q[i] + 39'(rvel[i]);
            end
            if (coh_hit) begin
              cdir_q[i] <= cdir_q[i] + 39'(o_q[i]);
            end
          end
          cnt_q <= 2'd0;
          if (sep_hit) begin
            state_q <= S_SDIV;
          end else if (last_j) begin
            pass_q  <= 1'b0;
            state_q <= S_UV_LD;
          end else begin
            j_q     <= j_q + SLOT_W'(1);
            state_q <= S_RD;
          end
        end
        S_SDIV: state_q <= S_SWAIT;
        S_SWAIT: begin
          if (div_rsp_i.done) begin
            if (sep_n > SEP_LIMIT) begin
              sep_q[cnt_q] <= SEP_LIMIT;
            end else if (sep_n < -SEP_LIMIT) begin
              sep_q[cnt_q] <= -SEP_LIMIT;
            end else begin
              sep_q[cnt_q] <= sep_n;
            end
            if (cnt_q != 2'd2) begin
              cnt_q   <= cnt_q + 2'd1;
              state_q <= S_SDIV;
            end else if (last_j) begin
              pass_q  <= 1'b0;
              state_q <= S_UV_LD;
            end else begin
              j_q     <= j_q + SLOT_W'(1);
              state_q <= S_RD;
            end
          end
        end
        S_UV_LD: begin
          for (int i = 0; i < 3; i++) begin
            uvm_q[i]   <= uv_src[i][38] ? 38'(-uv_src[i]) : 38'(uv_src[i]);
            uvneg_q[i] <= uv_src[i][38];
          end
          s_q     <= '0;
          state_q <= S_UV_NORM;
        end
        S_UV_NORM: begin
          cnt_q <= 2'd0;
          if (uv_zero) begin
            if (pass_q) begin
              coh_q   <= '{default: '0};
              step_q  <= '0;
              acc_q   <= '0;
              state_q <= S_FIN;
            end else begin
              ali_q   <= '{default: '0};
              pass_q  <= 1'b1;
              state_q <= S_UV_LD;
            end
          end else if (uv_big) begin
            for (int i = 0; i < 3; i++) begin
              uvm_q[i] <= uvm_q[i] >> 1;
            end
          end else begin
            state_q <= S_UV_SQ;
          end
        end
        S_UV_SQ: begin
          s_q <= s_q + 50'(uvm_q[cnt_q][23:0] * uvm_q[cnt_q][23:0]);
          if (cnt_q == 2'd2) begin
            state_q <= S_UV_ROOT;
          end else begin
            cnt_q <= cnt_q + 2'd1;
          end
        end
        S_UV_ROOT: state_q <= S_UV_RWAIT;
        S_UV_RWAIT: begin
          if (sqrt_rsp_i.done) begin
            len_q   <= sqrt_rsp_i.root;
            cnt_q   <= 2'd0;
            state_q <= S_UV_DIV;
          end
        end
        S_UV_DIV: state_q <= S_UV_DWAIT;
        S_UV_DWAIT: begin
          if (div_rsp_i.done) begin
            if (pass_q) begin
              coh_q[cnt_q] <= uvneg_q[cnt_q] ? -uq : uq;
            end else begin
              ali_q[cnt_q] <= uvneg_q[cnt_q] ? -uq : uq;
            end
            if (cnt_q != 2'd2) begin
              cnt_q   <= cnt_q + 2'd1;
              state_q <= S_UV_DIV;
            end else if (!pass_q) begin
              pass_q  <= 1'b1;
              state_q <= S_UV_LD;
            end else begin
              cnt_q   <= 2'd0;
              step_q  <= '0;
              acc_q   <= '0;
              state_q <= S_FIN;
            end
          end
        end
        S_FIN: begin
          case (step_q)
            3'd0: begin
              acc_q  <= acc_q + $signed({26'b0, mul_lo});
              step_q <= step_q + 3'd1;
            end
            3'd1: begin
              acc_q  <= acc_q + (66'(mul_hi) <<< 24);
              step_q <= step_q + 3'd1;
            end
            3'd2: begin
              acc_q  <= acc_q + 66'(mul_ali);
              step_q <= step_q + 3'd1;
            end
            3'd3: begin
              acc_q  <= acc_q + 66'(mul_coh);
              step_q <= step_q + 3'd1;
            end
            default: begin
              frc_q[cnt_q] <= sat;
              acc_q        <= '0;
              step_q       <= '0;
              if (cnt_q == 2'd2) begin
                state_q <= S_OUT;
              end else begin
                cnt_q <= cnt_q + 2'd1;
              end
            end
          endcase
        end
        S_OUT: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign res_valid_o   = (state_q == S_OUT);
  assign res_o.force_x = frc_q[0];
  assign res_o.force_y = frc_q[1];
  assign res_o.force_z = frc_q[2];
  assign res_o.status  = status_q;

  `BFF_ASSERT_IMP(a_div_free, div_req_o.start, !div_rsp_i.busy, "divider started while busy")
  `BFF_ASSERT_IMP(a_sqrt_free, sqrt_req_o.start, !sqrt_rsp_i.busy, "root started while busy")
  `BFF_ASSERT_NXT(a_res_hold, res_valid_o && !res_ready_i, res_valid_o && $stable(res_o), "result dropped before taken")

endmodule

FILE: rtl/core/boids_flocking_force_top.sv
// store and remove take effect in the cycle after leaving the queue
// query: walks every slot, dividing for each separation neighbor, then
//   normalizes the alignment and cohesion sums with the shared divider and
//   the root unit, weights the three forces and passes through the output register
// throughput: one store or remove per cycle while no query runs, one query at a time
// reset: member table empty, registers at defaults, no clearing pass needed
// ----------------------------------------------------------------------------
// boids_flocking_force_top
// flock member table with weighted separation, alignment and cohesion force
// ----------------------------------------------------------------------------
module boids_flocking_force_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  bff_pkg::in_item_t                 in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output bff_pkg::out_item_t                out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bff_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [bff_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import bff_pkg::*;

  // configuration registers
  cfg_t      cfg_q;

  // front to queue
  logic      push;
  cmd_t      push_cmd;
  logic      q_full;

  // queue to back
  logic      q_pop;
  cmd_t      q_head;
  logic      q_empty;

  // shared arithmetic units
  div_req_t  div_req;
  div_rsp_t  div_rsp;
  sqrt_req_t sqrt_req;
  sqrt_rsp_t sqrt_rsp;

  // result path
  logic      res_valid;
  logic      res_ready;
  out_item_t res;
  logic      out_valid_q;
  out_item_t out_data_q;

  // writes land any cycle; the host must write only while no query runs, the block does not enforce it
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sep_radius <= 31'd25600;
      cfg_q.ali_radius <= 31'd76800;
      cfg_q.coh_radius <= 31'd128000;
      cfg_q.sep_weight <= 16'd256;
      cfg_q.ali_weight <= 16'd256;
      cfg_q.coh_weight <= 16'd256;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_SEP_RADIUS: cfg_q.sep_radius <= cfg_data_i[30:0];
        CFG_ALI_RADIUS: cfg_q.ali_radius <= cfg_data_i[30:0];
        CFG_COH_RADIUS: cfg_q.coh_radius <= cfg_data_i[30:0];
        CFG_SEP_WEIGHT: cfg_q.sep_weight <= cfg_data_i[15:0];
        CFG_ALI_WEIGHT: cfg_q.ali_weight <= cfg_data_i[15:0];
        CFG_COH_WEIGHT: cfg_q.coh_weight <= cfg_data_i[15:0];
        default: ; // unmapped index, write dropped
      endcase
    end
  end

  // front: decode and enqueue
  bff_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  // decoupling queue
  bff_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_head),
    .empty_o (q_empty)
  );

  // back: member table and force sequencer
  bff_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_empty_i   (q_empty),
    .q_data_i    (q_head),
    .q_pop_o     (q_pop),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp),
    .sqrt_req_o  (sqrt_req),
    .sqrt_rsp_i  (sqrt_rsp),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // one divider serves separation and normalization
  bff_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // vector length for normalization
  bff_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sqrt_req),
    .rsp_o  (sqrt_rsp)
  );

  // output register parts the back from the consumer
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: test/tb_boids_flocking_force_top.sv
// ----------------------------------------------------------------------------
// tb_boids_flocking_force_top
// random and directed test of the flocking force unit against a scoreboard
// that keeps its own copy of the member table and predicts every query
// ----------------------------------------------------------------------------
module tb_boids_flocking_force_top;
  import bff_pkg::*;

  localparam longint CYCLE_LIMIT = 40_000_000;
  localparam int     RANDOM_ITEMS = 1300;
  localparam int     DRAIN_CYCLES = 8000;

  // member table copy and force prediction, plus the queue of awaited forces
  class force_scoreboard;
    bit                 occupied[MAX_MEMBERS];
    longint             px[MAX_MEMBERS], py[MAX_MEMBERS], pz[MAX_MEMBERS];
    longint             vx[MAX_MEMBERS], vy[MAX_MEMBERS], vz[MAX_MEMBERS];
    longint unsigned    sep_r, ali_r, coh_r, sep_w, ali_w, coh_w;
    out_item_t          awaited[$];
    int                 mismatches;

    function new();
      sep_r = 25600; ali_r = 76800; coh_r = 128000;
      sep_w = 256; ali_w = 256; coh_w = 256;
      mismatches = 0;
      foreach (occupied[i]) occupied[i] = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
      case (idx)
        CFG_SEP_RADIUS: sep_r = val[30:0];
        CFG_ALI_RADIUS: ali_r = val[30:0];
        CFG_COH_RADIUS: coh_r = val[30:0];
        CFG_SEP_WEIGHT: sep_w = val[15:0];
        CFG_ALI_WEIGHT: ali_w = val[15:0];
        CFG_COH_WEIGHT: coh_w = val[15:0];
        default: ;
      endcase
    endfunction

    function longint unsigned magnitude(longint x);
      return x < 0 ? longint'(0) - x : x;
    endfunction

    function longint unsigned int_sqrt(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function void unit_dir(input longint c[3], output longint u[3]);
      longint unsigned m[3], mx, s, len, q;
      int k;
      mx = 0; s = 0; k = 0;
      for (int i = 0; i < 3; i++) begin
        m[i] = magnitude(c[i]);
        if (m[i] > mx) mx = m[i];
      end
      if (mx == 0) begin
        u = '{0, 0, 0};
        return;
      end
      while ((mx >> k) >= (64'd1 << 24)) k++;
      for (int i = 0; i < 3; i++) begin
        m[i] >>= k;
        s += m[i] * m[i];
      end
      len = int_sqrt(s << 14);
      for (int i = 0; i < 3; i++) begin
        q = (m[i] << 23) / len;
        u[i] = c[i] < 0 ? -longint'(q) : longint'(q);
      end
    endfunction

    function out_item_t steering_force(int me);
      out_item_t        res;
      longint           my[3], o[3], sep[3], vsum[3], psum[3], ali[3], coh[3], cdir[3];
      longint           t, ccount, q;
      longint unsigned  d2, m, rs2, ra2, rc2;
      bit               far;
      my = '{px[me], py[me], pz[me]};
      sep = '{0, 0, 0}; vsum = '{0, 0, 0}; psum = '{0, 0, 0};
      ccount = 0;
      rs2 = sep_r * sep_r; ra2 = ali_r * ali_r; rc2 = coh_r * coh_r;
      for (int j = 0; j < MAX_MEMBERS; j++) begin
        if (!occupied[j] || j == me) continue;
        o = '{px[j] - my[0], py[j] - my[1], pz[j] - my[2]};
        d2 = 0;
        far = 0;
        for (int i = 0; i < 3; i++) begin
          m = magnitude(o[i]);
          if (m >= (64'd1 << 31)) far = 1;
          else d2 += m * m;
        end
        if (far) continue;
        if (d2 > 0 && d2 < rs2) begin
          for (int i = 0; i < 3; i++) begin
            q = longint'((magnitude(o[i]) << 24) / d2);
            sep[i] += o[i] < 0 ? q : -q;
            if (sep[i] > (64'sd1 <<< 46)) sep[i] = 64'sd1 <<< 46;
            if (sep[i] < -(64'sd1 <<< 46)) sep[i] = -(64'sd1 <<< 46);
          end
        end
        if (d2 < ra2) begin
          vsum[0] += vx[j]; vsum[1] += vy[j]; vsum[2] += vz[j];
        end
        if (d2 < rc2) begin
          psum[0] += px[j]; psum[1] += py[j]; psum[2] += pz[j];
          ccount++;
        end
      end
      unit_dir(vsum, ali);
      for (int i = 0; i < 3; i++) cdir[i] = ccount > 0 ? psum[i] - ccount * my[i] : 0;
      unit_dir(cdir, coh);
      for (int i = 0; i < 3; i++) begin
        t = sep[i] * longint'(sep_w) + ali[i] * longint'(ali_w) + coh[i] * longint'(coh_w);
        t = t / 256;
        if (t > 64'sd2147483647) t = 64'sd2147483647;
        if (t < -64'sd2147483648) t = -64'sd2147483648;
        case (i)
          0: res.force_x = t[31:0];
          1: res.force_y = t[31:0];
          default: res.force_z = t[31:0];
        endcase
      end
      res.status = STATUS_OK;
      return res;
    endfunction

    // accepted input item: update the table, queue the force a query causes
    function void note_item(in_item_t it);
      out_item_t empty_res;
      int s;
      s = it.slot;
      empty_res = '{force_x: 0, force_y: 0, force_z: 0, status: STATUS_EMPTY};
      case (func_e'(it.func))
        FUNC_STORE: begin
          occupied[s] = 1;
          px[s] = it.pos_x; py[s] = it.pos_y; pz[s] = it.pos_z;
          vx[s] = it.vel_x; vy[s] = it.vel_y; vz[s] = it.vel_z;
        end
        FUNC_REMOVE: occupied[s] = 0;
        FUNC_QUERY: begin
          if (!occupied[s]) awaited.push_back(empty_res);
          else awaited.push_back(steering_force(s));
        end
        default: ;
      endcase
    endfunction

    function void check_force(out_item_t got);
      out_item_t exp_res;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected force item %h", got);
        return;
      end
      exp_res = awaited.pop_front();
      if (got !== exp_res) begin
        mismatches++;
        if (mismatches <= 10)
          $display("force mismatch: exp x %h y %h z %h st %b, got x %h y %h z %h st %b",
                   exp_res.force_x, exp_res.force_y, exp_res.force_z, exp_res.status,
                   got.force_x, got.force_y, got.force_z, got.status);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  force_scoreboard sb;
  longint          cycles;
  bit              choke_req;
  logic signed [31:0] center_x, center_y, center_z;

  boids_flocking_force_top uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // result check first, then the input item accepted on the same edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_force(out_data);
      if (in_valid && !in_stall) sb.note_item(in_data);
    end
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    int n;
    out_stall <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (choke_req) begin
        // hold results back while the sender keeps pushing items
        out_stall <= 1'b1;
        repeat (4000) @(posedge clk);
        choke_req = 0;
      end
      n = gap_len();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // one item on the input channel, with a random gap before it
  task automatic send_item(in_item_t it);
    int n;
    n = gap_len();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic end_burst();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // wait until every force has come back, then let stores drain out
  task automatic wait_idle();
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_all(logic [31:0] sr, logic [31:0] ar, logic [31:0] cr,
                           logic [31:0] sw, logic [31:0] aw, logic [31:0] cw);
    write_reg(CFG_SEP_RADIUS, sr);
    write_reg(CFG_ALI_RADIUS, ar);
    write_reg(CFG_COH_RADIUS, cr);
    write_reg(CFG_SEP_WEIGHT, sw);
    write_reg(CFG_ALI_WEIGHT, aw);
    write_reg(CFG_COH_WEIGHT, cw);
  endtask

  // velocities keep their low 24 bits
  function automatic in_item_t make_item(func_e f, int s, int x, int y, int z,
                                         int a, int b, int c);
    in_item_t it;
    it.func = f; it.slot = SLOT_W'(s);
    it.pos_x = x; it.pos_y = y; it.pos_z = z;
    it.vel_x = 24'(a); it.vel_y = 24'(b); it.vel_z = 24'(c);
    return it;
  endfunction

  // position near the flock center, or anywhere for far members
  function automatic logic [31:0] rand_pos(logic signed [31:0] ctr);
    if ($urandom_range(99) < 10) return $urandom;
    return ctr + $signed($urandom_range(0, 307200)) - 153600;
  endfunction

  function automatic in_item_t rand_item();
    int r;
    func_e f;
    r = $urandom_range(99);
    if (r < 50) f = FUNC_STORE;
    else if (r < 64) f = FUNC_REMOVE;
    else if (r < 96) f = FUNC_QUERY;
    else f = FUNC_RSVD;
    return make_item(f, $urandom_range(63), rand_pos(center_x), rand_pos(center_y),
                     rand_pos(center_z), $urandom, $urandom, $urandom);
  endfunction

  task automatic random_phase(int count);
    center_x = $signed($urandom) >>> 1;
    center_y = $signed($urandom) >>> 1;
    center_z = $signed($urandom) >>> 1;
    for (int i = 0; i < count; i++) send_item(rand_item());
    end_burst();
  endtask

  initial begin
    sb = new();
    cycles = 0;
    choke_req = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, far and coincident members, empty slots, unused code
    send_item(make_item(FUNC_QUERY, 5, 0, 0, 0, 0, 0, 0));
    send_item(make_item(FUNC_STORE, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                        32'h007fffff, 32'h007fffff, 32'h007fffff));
    send_item(make_item(FUNC_STORE, 63, 32'h80000000, 32'h80000000, 32'h80000000,
                        32'hff800000, 32'hff800000, 32'hff800000));
    send_item(make_item(FUNC_QUERY, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_item(FUNC_STORE, 1, 1000, -2000, 300, 256, -256, 0));
    send_item(make_item(FUNC_STORE, 2, 1000, -2000, 300, -500, 700, 3));
    send_item(make_item(FUNC_STORE, 3, 1200, -2000, 300, 0, 0, 0));
    send_item(make_item(FUNC_STORE, 4, 1000, 20000, -9000, 10, 20, 30));
    send_item(make_item(FUNC_QUERY, 1, 0, 0, 0, 0, 0, 0));
    send_item(make_item(FUNC_QUERY, 3, 0, 0, 0, 0, 0, 0));
    send_item(make_item(FUNC_REMOVE, 5, 0, 0, 0, 0, 0, 0));
    send_item(make_item(FUNC_REMOVE, 63, 0, 0, 0, 0, 0, 0));
    send_item(make_item(FUNC_QUERY, 63, 0, 0, 0, 0, 0, 0));
    send_item(make_item(FUNC_RSVD, 1, 0, 0, 0, 0, 0, 0));
    send_item(make_item(FUNC_STORE, 3, 1100, -2050, 290, 1, 2, 3));
    send_item(make_item(FUNC_QUERY, 2, 0, 0, 0, 0, 0, 0));
    send_item(make_item(FUNC_QUERY, 4, 0, 0, 0, 0, 0, 0));
    end_burst();
    wait_idle();

    // defaults, with one long receiver hold-off
    choke_req = 1;
    random_phase(400);
    wait_idle();

    // extremes: zero radii and weights, then widest radii and full weights
    write_all(0, 0, 0, 0, 0, 0);
    random_phase(150);
    wait_idle();
    write_all(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'hffff, 32'hffff, 32'hffff);
    random_phase(250);
    wait_idle();

    // random settings
    for (int p = 0; p < 2; p++) begin
      write_all($urandom_range(0, 200000), $urandom_range(0, 400000),
                $urandom_range(0, 600000), $urandom_range(0, 65535),
                $urandom_range(0, 65535), $urandom_range(0, 65535));
      random_phase(250);
      wait_idle();
    end

    if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
